// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the tile address generator.
// Each macro wraps one clocked concurrent assertion with an active-low disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/ggta_pkg.sv -----
// Types and constants of the grouped GEMM tile address generator.
// Used by the descriptor memory, the top level, the checker and the testbench.
package ggta_pkg;

  localparam int unsigned TileLog2    = 4;
  localparam int unsigned MaxColTiles = 64;
  localparam int unsigned InTdataW    = 176;
  localparam int unsigned OutTdataW   = 136;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [0:0] {
    FUNC_LOAD    = 1'b0,
    FUNC_RESOLVE = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    CFG_GROUP_COUNT = 1'b0,
    CFG_TILE_TOTAL  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_DIV,
    ST_MAC,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef enum logic [1:0] {
    MAC_A_ROW,
    MAC_B_COL,
    MAC_C_TILE
  } mac_op_e;

  // One group descriptor as held in the table.
  typedef struct packed {
    logic [15:0] first_tile;
    logic [6:0]  col_tiles;
    logic [31:0] a_offset;
    logic [31:0] b_offset;
    logic [31:0] c_offset;
    logic [10:0] a_stride;
    logic [10:0] b_stride;
    logic [10:0] c_stride;
  } desc_t;

  // Input tdata, first field in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [10:0] c_stride;
    logic [10:0] b_stride;
    logic [10:0] a_stride;
    logic [31:0] c_offset;
    logic [31:0] b_offset;
    logic [31:0] a_offset;
    logic [6:0]  col_tiles;
    logic [15:0] first_tile;
    logic [15:0] tile_number;
    logic [3:0]  group_index;
  } in_data_t;

  // Output tdata, first field in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [9:0]  k_offset;
    logic [31:0] c_addr;
    logic [31:0] b_addr;
    logic [31:0] a_addr;
    logic [5:0]  col_tile;
    logic [15:0] row_tile;
    logic [3:0]  group;
  } out_data_t;

endpackage

// ----- rtl/ggta_div.sv -----
// Restoring divider, one quotient bit per cycle, for the tile index split.
// Depends on nothing outside this file.
module ggta_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o,
  output logic [5:0]  rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [6:0]  div_q, div_d;
  logic [6:0]  partial;
  logic        fits;

  // The running remainder stays below the divisor, at most 64, so six bits hold it.
  assign partial = {rem_q, quo_q[15]};
  assign fits    = partial >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd16;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[14:0], fits};
      rem_d = fits ? 6'(partial - div_q) : partial[5:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/ggta_desc_mem.sv -----
// Group descriptor table: one write port, one registered read port.
// Depends on ggta_pkg for the descriptor type.
module ggta_desc_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  ggta_pkg::desc_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output ggta_pkg::desc_t      rdata_o
);
  import ggta_pkg::*;

  desc_t mem_q [Depth];
  desc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/grouped_gemm_tile_address_generator.sv -----
// Grouped GEMM tile address generator.
// Input stream (s_axis_*): a load transfer (tuser = 0) writes one group descriptor into
// the table and gives no result; a resolve transfer (tuser = 1) names a flat output
// tile. A resolve gives one result per 16-wide K step with the A, B and C addresses of
// that tile, tlast on the final one; a tile at or beyond the tile total gives a single
// result with tuser (out of range) set, tlast set and all data zero.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 = group count, 1 = tile total); write it only while the block is idle.
// Sequence: a load is written into the table as it is accepted. A resolve is accepted,
// starts the table read, scans the descriptor entries one at a time (last to first),
// runs the serial divider, forms the A row, B column and C tile addresses in turn on
// the shared multiply-add unit, and then writes one result per K step while the output
// is taken. An out-of-range resolve goes straight to its flagged result.
// The input is ready only in the idle state; it is ready again as soon as the final
// result sits in the output register, so the next transfer can be taken while that
// result waits. When the receiver stalls, the output register holds its result and the
// sequencer waits for it before writing the next step.
// Reset sets group count to 1 and tile total to 0 and empties the output; the
// descriptor table is not cleared and must be loaded before it is used.
module grouped_gemm_tile_address_generator #(
  parameter int unsigned MAX_GROUPS  = 16,
  parameter int unsigned MAX_K_STEPS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [ggta_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // group_index, tile_number, first_tile, col_tiles, a_offset, b_offset, c_offset,
  // a_stride, b_stride, c_stride, zero padding
  input  logic [ggta_pkg::InTdataW-1:0]  s_axis_tdata,
  // func
  input  logic                           s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // group, row_tile, col_tile, a_addr, b_addr, c_addr, k_offset, zero padding
  output logic [ggta_pkg::OutTdataW-1:0] m_axis_tdata,
  // out_of_range
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import ggta_pkg::*;

  localparam int unsigned GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned KW = (MAX_K_STEPS > 1) ? $clog2(MAX_K_STEPS) : 1;

  // Configuration registers.
  logic [4:0]  group_count_q;
  logic [15:0] tile_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= 5'd1;
      tile_total_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GROUP_COUNT: group_count_q <= cfg_wdata_i[4:0];
        CFG_TILE_TOTAL:  tile_total_q  <= cfg_wdata_i[15:0];
      endcase
    end
  end

  // Input decode.
  in_data_t in_data;
  logic     in_acc;
  logic     is_resolve;
  logic     tile_err;
  logic     load_ok;

  assign in_data    = in_data_t'(s_axis_tdata);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_resolve = func_e'(s_axis_tuser) == FUNC_RESOLVE;
  assign tile_err   = in_data.tile_number >= tile_total_q;
  assign load_ok    = 7'(in_data.group_index) < 7'(MAX_GROUPS);

  // First entry of the scan: the group count less one, saturated to the last table entry.
  logic [6:0]    gc_ext;
  logic [GW-1:0] scan_first;

  assign gc_ext = 7'(group_count_q);

  always_comb begin
    if (gc_ext == 7'd0) begin
      scan_first = '0;
    end else if (gc_ext > 7'(MAX_GROUPS)) begin
      scan_first = GW'(MAX_GROUPS - 1);
    end else begin
      scan_first = GW'(gc_ext - 7'd1);
    end
  end

  // Sequencer state and control.
  state_e        state_q, state_d;
  logic [GW-1:0] scan_idx_q;
  logic [15:0]   tile_q;
  logic [GW-1:0] g_q;
  logic [KW-1:0] k_q;
  logic [KW-1:0] last_k_q;
  mac_op_e       mac_op_q;
  logic          out_free;
  logic          hit;
  logic          div_done;

  // Descriptor table.
  desc_t         wr_desc;
  desc_t         rd_desc;
  logic          mem_we;
  logic [GW-1:0] mem_raddr;

  assign wr_desc.first_tile = in_data.first_tile;
  assign wr_desc.col_tiles  = in_data.col_tiles;
  assign wr_desc.a_offset   = in_data.a_offset;
  assign wr_desc.b_offset   = in_data.b_offset;
  assign wr_desc.c_offset   = in_data.c_offset;
  assign wr_desc.a_stride   = in_data.a_stride;
  assign wr_desc.b_stride   = in_data.b_stride;
  assign wr_desc.c_stride   = in_data.c_stride;

  ggta_desc_mem #(
    .Depth (MAX_GROUPS),
    .AddrW (GW)
  ) u_desc_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (GW'(in_data.group_index)),
    .wdata_i (wr_desc),
    .raddr_i (mem_raddr),
    .rdata_o (rd_desc)
  );

  // The scan walks down from the last entry; entry zero is taken whether or not
  // its base matches, which also covers a group count of zero.
  assign hit      = (tile_q >= rd_desc.first_tile) || (scan_idx_q == '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Operands for the divider, taken straight from the entry that was found.
  logic [15:0] local_idx;
  logic [6:0]  ct_clamped;
  logic [7:0]  steps_raw;
  logic [7:0]  steps_sat;

  assign local_idx = tile_q - rd_desc.first_tile;
  assign steps_raw = 8'((12'(rd_desc.a_stride) + 12'd15) >> TileLog2);

  always_comb begin
    if (rd_desc.col_tiles == 7'd0) begin
      ct_clamped = 7'd1;
    end else if (rd_desc.col_tiles > 7'(MaxColTiles)) begin
      ct_clamped = 7'(MaxColTiles);
    end else begin
      ct_clamped = rd_desc.col_tiles;
    end
    if (steps_raw == 8'd0) begin
      steps_sat = 8'd1;
    end else if (steps_raw > 8'(MAX_K_STEPS)) begin
      steps_sat = 8'(MAX_K_STEPS);
    end else begin
      steps_sat = steps_raw;
    end
  end

  logic        div_start;
  logic [15:0] row_tile;
  logic [5:0]  col_tile;

  ggta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (local_idx),
    .divisor_i  (ct_clamped),
    .done_o     (div_done),
    .quot_o     (row_tile),
    .rem_o      (col_tile)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_resolve) begin
          state_d = tile_err ? ST_ERR : ST_SCAN;
        end
      end
      ST_SCAN: state_d = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_op_q == MAC_C_TILE) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (k_q == last_k_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  logic out_load_step;
  logic out_load_err;

  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = scan_idx_q;
    div_start     = 1'b0;
    out_load_step = 1'b0;
    out_load_err  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_we        = in_acc && !is_resolve && load_ok;
      end
      ST_SCAN: mem_raddr = scan_idx_q;
      ST_CMP: begin
        // Fetch the next lower entry ahead so that a miss can compare it straight away.
        mem_raddr = scan_idx_q - GW'(1);
        div_start = hit;
      end
      ST_EMIT: out_load_step = out_free;
      ST_ERR:  out_load_err  = out_free;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mac_op_q <= MAC_A_ROW;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_MAC) begin
        mac_op_q <= MAC_A_ROW;
      end else if (mac_op_q == MAC_A_ROW) begin
        mac_op_q <= MAC_B_COL;
      end else begin
        mac_op_q <= MAC_C_TILE;
      end
      if (div_start) begin
        k_q <= '0;
      end else if (out_load_step) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  // Latched descriptor and scan position.
  logic [31:0] a_off_q, b_off_q, c_off_q;
  logic [10:0] a_str_q, b_str_q, c_str_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tile_q     <= in_data.tile_number;
      scan_idx_q <= scan_first;
    end else if ((state_q == ST_CMP) && !hit) begin
      scan_idx_q <= scan_idx_q - GW'(1);
    end
    if (div_start) begin
      g_q      <= scan_idx_q;
      a_off_q  <= rd_desc.a_offset;
      b_off_q  <= rd_desc.b_offset;
      c_off_q  <= rd_desc.c_offset;
      a_str_q  <= rd_desc.a_stride;
      b_str_q  <= rd_desc.b_stride;
      c_str_q  <= rd_desc.c_stride;
      last_k_q <= KW'(steps_sat - 8'd1);
    end
  end

  // Shared multiply-add unit: base + (x * stride) * 16, one operation a cycle.
  logic [15:0] mac_x;
  logic [10:0] mac_y;
  logic [31:0] mac_base;
  logic [26:0] mac_prod;
  logic [31:0] mac_sum;
  logic [31:0] arow_q, bcol_q, caddr_q;

  always_comb begin
    case (mac_op_q)
      MAC_A_ROW: begin
        mac_x    = row_tile;
        mac_y    = a_str_q;
        mac_base = a_off_q;
      end
      MAC_B_COL: begin
        mac_x    = 16'(col_tile);
        mac_y    = b_str_q;
        mac_base = b_off_q;
      end
      default: begin
        mac_x    = row_tile;
        mac_y    = c_str_q;
        mac_base = c_off_q + (32'(col_tile) << TileLog2);
      end
    endcase
  end

  assign mac_prod = 27'(mac_x) * 27'(mac_y);
  assign mac_sum  = mac_base + (32'(mac_prod) << TileLog2);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAC) begin
      case (mac_op_q)
        MAC_A_ROW: arow_q  <= mac_sum;
        MAC_B_COL: bcol_q  <= mac_sum;
        default:   caddr_q <= mac_sum;
      endcase
    end
  end

  // Output register.
  logic [31:0] k_off;
  out_data_t   step_data;
  out_data_t   out_data_q;
  logic        out_valid_q;
  logic        out_err_q;
  logic        out_last_q;

  assign k_off = 32'(k_q) << TileLog2;

  assign step_data.pad      = '0;
  assign step_data.group    = 4'(g_q);
  assign step_data.row_tile = row_tile;
  assign step_data.col_tile = col_tile;
  assign step_data.a_addr   = arow_q + k_off;
  assign step_data.b_addr   = bcol_q + k_off;
  assign step_data.c_addr   = caddr_q;
  assign step_data.k_offset = k_off[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_step || out_load_err) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_step) begin
      out_data_q <= step_data;
      out_err_q  <= 1'b0;
      out_last_q <= k_q == last_k_q;
    end else if (out_load_err) begin
      out_data_q <= '0;
      out_err_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/ggta_checker.sv -----
// Port-level checks for the grouped GEMM tile address generator, bound to the top level.
// Depends on ggta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ggta_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [0:0]                     cfg_idx_i,
  input logic [ggta_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ggta_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ggta_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import ggta_pkg::*;

  // A stalled result keeps its contents until it is taken.
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result changed while stalled")

  // A rejected tile is a single, final result with all data zero.
  `ASSERT_AT(a_err_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "malformed out-of-range result")

  // While the steps of a tile are still being produced no new transfer is taken.
  `ASSERT_NEVER(a_busy_steps, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast && s_axis_tready, "input ready in the middle of a tile")

  // Taking an input transfer never produces a result in the following cycle.
  `ASSERT_AT(a_no_early_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid, "result appeared straight after an input transfer")

endmodule

bind grouped_gemm_tile_address_generator ggta_checker u_ggta_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the grouped GEMM tile address generator.
// Depends on ggta_pkg and the top level; a directed table and random phases are checked
// against a predictor of the descriptor table and the address arithmetic.
`timescale 1ns / 1ps

module tb_top;
  import ggta_pkg::*;

  localparam int unsigned MaxGroups     = 16;
  localparam int unsigned MaxKSteps     = 64;
  localparam int unsigned TileEdge      = 16;
  localparam int unsigned MaxGap        = 11;
  // Allows for the longest resolve, with 16 scanned entries and 64 K steps.
  localparam int unsigned SettleCycles  = 120;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 33;
  // Watchdog limit. The worst correct run has every item giving 64 results, each held off
  // by the receiver, plus the sender's gaps and the block's own processing.
  localparam int unsigned RunLimit      = 1_500_000;

  // One result as it is expected on the output stream.
  typedef struct packed {
    logic      oor;
    logic      last;
    out_data_t data;
  } tile_result_t;

  // Rows of the directed table are either a stream transfer or a register write.
  typedef enum logic [0:0] {
    ROW_XFER,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    func_e       func;
    in_data_t    data;
    bit          typed_reject;
    cfg_reg_e    cfg_sel;
    logic [15:0] cfg_val;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [0:0]           cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // Predictor state: a private copy of the descriptor table and the two registers.
  desc_t        desc_tbl [MaxGroups];
  logic [4:0]   grp_count  = 5'd1;
  logic [15:0]  tile_limit = 16'd0;
  tile_result_t pending_fetches [$];
  plan_row_t    directed_plan [$];

  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit           gaps_on        = 1'b1;
  bit           stall_request  = 1'b0;

  grouped_gemm_tile_address_generator #(
    .MAX_GROUPS  (MaxGroups),
    .MAX_K_STEPS (MaxKSteps)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock, starting low.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Works out the results of one resolve transfer and queues them. A tile at or beyond
  // the tile total gives a single flagged result; otherwise the valid entries are scanned
  // from the top down for the first whose base is not above the tile, falling back to
  // entry 0, and one result is queued per 16-wide K step.
  function automatic void resolve_tile(logic [15:0] tile);
    desc_t        e;
    tile_result_t r;
    int unsigned  scan, g, ct, steps;
    logic [15:0]  offs, row;
    logic [5:0]   col;
    logic [31:0]  a_row, b_col, c_tile, k;
    if (tile >= tile_limit) begin
      pending_fetches.push_back(tile_result_t'{oor: 1'b1, last: 1'b1, data: '0});
      return;
    end
    scan = (grp_count > MaxGroups) ? MaxGroups : grp_count;
    g = 0;
    for (int i = scan; i > 0; i--) begin
      if (tile >= desc_tbl[i-1].first_tile) begin
        g = i - 1;
        break;
      end
    end
    e = desc_tbl[g];
    // A tile below the chosen base wraps within 16 bits.
    offs = tile - e.first_tile;
    ct = e.col_tiles;
    if (ct == 0) ct = 1;
    if (ct > 64) ct = 64;
    row = offs / ct;
    col = offs % ct;
    steps = (32'(e.a_stride) + 32'd15) >> 4;
    if (steps < 1) steps = 1;
    if (steps > MaxKSteps) steps = MaxKSteps;
    a_row  = e.a_offset + 32'(row) * TileEdge * 32'(e.a_stride);
    b_col  = e.b_offset + 32'(col) * TileEdge * 32'(e.b_stride);
    c_tile = e.c_offset + 32'(row) * TileEdge * 32'(e.c_stride) + 32'(col) * TileEdge;
    for (int unsigned s = 0; s < steps; s++) begin
      k = s * TileEdge;
      r = '0;
      r.last          = (s + 1 == steps);
      r.data.group    = g[3:0];
      r.data.row_tile = row;
      r.data.col_tile = col;
      r.data.a_addr   = a_row + k;
      r.data.b_addr   = b_col + k;
      r.data.c_addr   = c_tile;
      r.data.k_offset = k[9:0];
      pending_fetches.push_back(r);
    end
  endfunction

  // Every field random at full width; the padding stays zero.
  function automatic in_data_t random_payload();
    in_data_t d;
    d.pad         = '0;
    d.group_index = $urandom_range(0, 15);
    d.tile_number = $urandom_range(0, 16'hFFFF);
    d.first_tile  = $urandom_range(0, 16'hFFFF);
    d.col_tiles   = $urandom_range(0, 127);
    d.a_offset    = $urandom;
    d.b_offset    = $urandom;
    d.c_offset    = $urandom;
    d.a_stride    = $urandom_range(0, 2047);
    d.b_stride    = $urandom_range(0, 2047);
    d.c_stride    = $urandom_range(0, 2047);
    return d;
  endfunction

  function automatic in_data_t resolve_req(logic [15:0] tile);
    in_data_t d;
    d = random_payload();
    d.tile_number = tile;
    return d;
  endfunction

  function automatic in_data_t load_req(logic [3:0] idx, logic [15:0] first, logic [6:0] cols,
                                        logic [31:0] ao, logic [31:0] bo, logic [31:0] co,
                                        logic [10:0] a_str, logic [10:0] b_str,
                                        logic [10:0] c_str);
    in_data_t d;
    d = random_payload();
    d.group_index = idx;
    d.first_tile  = first;
    d.col_tiles   = cols;
    d.a_offset    = ao;
    d.b_offset    = bo;
    d.c_offset    = co;
    d.a_stride    = a_str;
    d.b_stride    = b_str;
    d.c_stride    = c_str;
    return d;
  endfunction

  // Mostly whole 16-element strides giving a handful of K steps, now and then the
  // extremes and odd values that need rounding up or saturation.
  function automatic logic [10:0] rand_stride();
    case ($urandom_range(0, 19))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'd1024;
      3:       return $urandom_range(0, 2047);
      default: return 11'(TileEdge * $urandom_range(1, 12));
    endcase
  endfunction

  // Column-tile counts, including zero and values above the 64-tile ceiling.
  function automatic logic [6:0] rand_cols();
    case ($urandom_range(0, 15))
      0:       return 7'd0;
      1:       return $urandom_range(65, 127);
      2:       return 7'd64;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Offers one transfer after a random gap and waits for the handshake. The prediction is
  // made at the accepting edge, so loads reach the table copy in stream order. Valid is
  // only lowered when a gap is drawn, so back-to-back transfers keep it high.
  task automatic send_transfer(func_e fn, in_data_t payload, bit typed_reject);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= payload;
    do @(posedge clk_i); while (!s_axis_tready);
    if (fn == FUNC_LOAD) begin
      desc_tbl[payload.group_index] = '{first_tile: payload.first_tile,
                                        col_tiles:  payload.col_tiles,
                                        a_offset:   payload.a_offset,
                                        b_offset:   payload.b_offset,
                                        c_offset:   payload.c_offset,
                                        a_stride:   payload.a_stride,
                                        b_stride:   payload.b_stride,
                                        c_stride:   payload.c_stride};
    end else if (typed_reject) begin
      pending_fetches.push_back(tile_result_t'{oor: 1'b1, last: 1'b1, data: '0});
    end else begin
      resolve_tile(payload.tile_number);
    end
    @(negedge clk_i);
  endtask

  // Stops offering, waits for every queued result, then allows for a load or the tail of
  // a resolve still in flight so that the block is truly idle.
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_fetches.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One-cycle register write, followed by a gap that keeps back-to-back writes apart.
  task automatic write_cfg(cfg_reg_e sel, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_GROUP_COUNT) grp_count = val[4:0];
    else tile_limit = val;
    @(negedge clk_i);
  endtask

  // Result side. Ready is held low for a random number of cycles before each transfer,
  // or for a long stretch when the stimulus asks for back-pressure. It is only lowered
  // when a hold is drawn, so a run with no holds keeps it high throughout.
  initial begin : result_sink
    int unsigned hold;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        hold = LongHold;
      end else begin
        hold = gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Each accepted result is compared with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    tile_result_t want;
    out_data_t    got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_fetches.size() == 0) begin
        $error("result transfer with nothing expected: group %0d, k_offset %0d",
               got.group, got.k_offset);
        mismatch_count++;
      end else begin
        want = pending_fetches.pop_front();
        check_field("out_of_range", 32'(want.oor),           32'(m_axis_tuser));
        check_field("group",        32'(want.data.group),    32'(got.group));
        check_field("row_tile",     32'(want.data.row_tile), 32'(got.row_tile));
        check_field("col_tile",     32'(want.data.col_tile), 32'(got.col_tile));
        check_field("a_addr",       want.data.a_addr,        got.a_addr);
        check_field("b_addr",       want.data.b_addr,        got.b_addr);
        check_field("c_addr",       want.data.c_addr,        got.c_addr);
        check_field("k_offset",     32'(want.data.k_offset), 32'(got.k_offset));
        check_field("last",         32'(want.last),          32'(m_axis_tlast));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0]  gc;
    logic [15:0] tt, first;
    int unsigned nload, step, pick;
    in_data_t    d;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_GROUP_COUNT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOAD;
    foreach (desc_tbl[i]) desc_tbl[i] = '0;

    // Directed part. After reset the tile total is zero, so any resolve is rejected and
    // reads no descriptor. The whole table is then loaded before anything is resolved.
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd0), 1'b1,
                              CFG_GROUP_COUNT, 16'd0});
    directed_plan.push_back('{ROW_XFER, FUNC_LOAD,
                              load_req(4'd0, 16'd0, 7'd0, 32'h0, 32'hFFFF_FFFF,
                                       32'hFFFF_FFF0, 11'd0, 11'd2047, 11'd2047),
                              1'b0, CFG_GROUP_COUNT, 16'd0});
    for (int i = 1; i < 15; i++) begin
      directed_plan.push_back('{ROW_XFER, FUNC_LOAD,
                                load_req(4'(i), 16'(i * 40),
                                         (i == 13) ? 7'd64 : (i == 14) ? 7'd127 : 7'(1 + i * 3),
                                         32'h0100_0000 * i + 32'h10, 32'hFFFF_0000 - 32'h1000 * i,
                                         32'h0010_0000 * i, 11'(16 * i + (i == 5)),
                                         11'(16 * (16 - i)), 11'(1024 - 16 * i)),
                                1'b0, CFG_GROUP_COUNT, 16'd0});
    end
    directed_plan.push_back('{ROW_XFER, FUNC_LOAD,
                              load_req(4'd15, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 11'd2047, 11'd2047, 11'd2047),
                              1'b0, CFG_GROUP_COUNT, 16'd0});
    directed_plan.push_back('{ROW_CFG, FUNC_LOAD, '0, 1'b0, CFG_GROUP_COUNT, 16'd16});
    directed_plan.push_back('{ROW_CFG, FUNC_LOAD, '0, 1'b0, CFG_TILE_TOTAL, 16'hFFFF});
    // The top tile number always equals or exceeds the largest tile total.
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'hFFFF), 1'b1,
                              CFG_GROUP_COUNT, 16'd0});
    // Highest valid tile: the top entry sits above it, entry 14 clips 127 columns to 64.
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'hFFFE), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    // Tile 0: entry 0 with zero column tiles and zero A stride, so one K step.
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd0), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd555), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    // Entry 5 has a stride that is not a whole number of K steps.
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd215), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    // A zero group count scans nothing and falls back to entry 0.
    directed_plan.push_back('{ROW_CFG, FUNC_LOAD, '0, 1'b0, CFG_GROUP_COUNT, 16'd0});
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd300), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    // A group count above the table size saturates.
    directed_plan.push_back('{ROW_CFG, FUNC_LOAD, '0, 1'b0, CFG_GROUP_COUNT, 16'd31});
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd65000), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});
    // No entry matches a small tile once entry 0 starts high: entry 0 is used, the local
    // index wraps, and the widest A stride gives the full 64 K steps.
    directed_plan.push_back('{ROW_XFER, FUNC_LOAD,
                              load_req(4'd0, 16'h8000, 7'd64, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'hFFFF_FF00, 11'd2047, 11'd2047, 11'd2047),
                              1'b0, CFG_GROUP_COUNT, 16'd0});
    directed_plan.push_back('{ROW_CFG, FUNC_LOAD, '0, 1'b0, CFG_GROUP_COUNT, 16'd16});
    directed_plan.push_back('{ROW_XFER, FUNC_RESOLVE, resolve_req(16'd5), 1'b0,
                              CFG_GROUP_COUNT, 16'd0});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        await_idle();
        write_cfg(directed_plan[r].cfg_sel, directed_plan[r].cfg_val);
      end else begin
        send_transfer(directed_plan[r].func, directed_plan[r].data,
                      directed_plan[r].typed_reject);
      end
    end

    // Random phases. Each one sets both registers, loads a well-formed table with rising
    // first tiles over the scanned entries, then mixes in-range resolves with rejected
    // tiles and the odd reload, some well-formed and some pure noise.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin gc = 5'd16; tt = 16'hFFFF; end
        1:       begin gc = 5'd1;  tt = $urandom_range(1, 300); end
        2:       begin gc = 5'd16; tt = $urandom_range(200, 2000); end
        3:       begin gc = 5'd0;  tt = $urandom_range(1, 2000); end
        4:       begin gc = 5'd31; tt = $urandom_range(1, 2000); end
        5:       begin gc = $urandom_range(1, 16); tt = 16'd0; end
        default: begin gc = $urandom_range(1, 16); tt = $urandom_range(1, 16'hFFFF); end
      endcase
      await_idle();
      write_cfg(CFG_GROUP_COUNT, 16'(gc));
      write_cfg(CFG_TILE_TOTAL, tt);
      // Phase 2 runs without gaps on either side, so the long hold fills the block.
      gaps_on = (ph != 2) && ($urandom_range(0, 4) != 0);

      nload = (gc == 0) ? 1 : (gc > MaxGroups) ? MaxGroups : gc;
      step  = (tt / nload == 0) ? 1 : tt / nload;
      for (int j = 0; j < nload; j++) begin
        if (j == 0) first = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, step)) : 16'd0;
        else first = 16'(j * step + $urandom_range(0, step / 2));
        send_transfer(FUNC_LOAD, load_req(4'(j), first, rand_cols(), $urandom, $urandom,
                                          $urandom, rand_stride(), rand_stride(),
                                          rand_stride()), 1'b0);
      end

      if (ph == 2) stall_request = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Halfway through phase 3 the sender waits for every result before going on.
        if (ph == 3 && n == ItemsPerPhase / 2) await_idle();
        pick = $urandom_range(0, 99);
        if (pick < 78 && tile_limit != 0) begin
          send_transfer(FUNC_RESOLVE, resolve_req($urandom_range(0, tile_limit - 1)), 1'b0);
        end else if (pick < 88) begin
          send_transfer(FUNC_RESOLVE, resolve_req($urandom_range(tile_limit, 16'hFFFF)),
                        1'b0);
        end else if (pick < 94) begin
          d = load_req($urandom_range(0, 15), $urandom_range(0, tt), rand_cols(), $urandom,
                       $urandom, $urandom, rand_stride(), rand_stride(), rand_stride());
          send_transfer(FUNC_LOAD, d, 1'b0);
        end else begin
          send_transfer(FUNC_LOAD, random_payload(), 1'b0);
        end
      end
    end

    await_idle();
    if (mismatch_count == 0 && pending_fetches.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- grouped_gemm_tile_address_generator.f -----
+incdir+rtl
rtl/ggta_pkg.sv
rtl/ggta_div.sv
rtl/ggta_desc_mem.sv
rtl/grouped_gemm_tile_address_generator.sv
rtl/ggta_checker.sv
sim/tb_top.sv
